>>> design/gamepad_button_auto_repeat_defines.svh
// ----------------------------------------------------------------------------
// Gamepad button auto-repeat: assertion macros
// Shared property shapes for the auto-repeat block; clocked on clock and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_BUTTON_AUTO_REPEAT_DEFINES_SVH
`define GAMEPAD_BUTTON_AUTO_REPEAT_DEFINES_SVH

// Check cons in the same cycle as ante
`define GBAR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante
`define GBAR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/gbar_pkg.sv
// ----------------------------------------------------------------------------
// Gamepad button auto-repeat: package
// Field widths, result codes, register indexes and the button lookups.
// ----------------------------------------------------------------------------
`default_nettype none

package gbar_pkg;

   localparam int NUM_BUTTONS = 25;
   localparam int AXIS_COUNT  = 10;
   localparam int TICK_WIDTH  = 32;
   localparam int TICK_EXT_W  = 64;
   localparam int REQ_DATA_W  = 128;
   localparam int RSP_DATA_W  = 24;
   localparam int RSP_USER_W  = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Result kinds
   localparam logic KIND_AXIS   = 1'b0;
   localparam logic KIND_BUTTON = 1'b1;

   // Button event codes
   localparam logic [1:0] EV_PRESS   = 2'd0;
   localparam logic [1:0] EV_RELEASE = 2'd1;
   localparam logic [1:0] EV_REPEAT  = 2'd2;

   // Register indexes
   localparam logic [2:0] REG_LEFT_DZ     = 3'd0;
   localparam logic [2:0] REG_RIGHT_DZ    = 3'd1;
   localparam logic [2:0] REG_LEFT_THR    = 3'd2;
   localparam logic [2:0] REG_RIGHT_THR   = 3'd3;
   localparam logic [2:0] REG_FIRST_DELAY = 3'd4;
   localparam logic [2:0] REG_PERIOD      = 3'd5;
   localparam logic [2:0] REG_PAD_ID      = 3'd6;

   // Button numbers driven by analog inputs
   localparam int BTN_L2     = 10;
   localparam int BTN_R2     = 13;
   localparam int BTN_LS_UP  = 17;
   localparam int BTN_LS_DN  = 18;
   localparam int BTN_LS_LT  = 19;
   localparam int BTN_LS_RT  = 20;
   localparam int BTN_RS_UP  = 21;
   localparam int BTN_RS_DN  = 22;
   localparam int BTN_RS_LT  = 23;
   localparam int BTN_RS_RT  = 24;

   // One result before pad number and end-of-poll mark are attached
   typedef struct packed {
      logic        kind;
      logic [4:0]  key;
      logic [1:0]  event_res;
      logic [15:0] axis_value;
   } result_type;

   // Map the digital mask onto button numbers 0..16; touchpad, L2 and R2
   // have no mask bit
   function automatic logic [16:0] mask_to_buttons(input logic [15:0] mask);
      logic [16:0] b;
      b      = '0;
      b[0]   = mask[14];
      b[1]   = mask[12];
      b[2]   = mask[13];
      b[3]   = mask[15];
      b[4]   = mask[0];
      b[5]   = mask[1];
      b[6]   = mask[2];
      b[7]   = mask[3];
      b[9]   = mask[8];
      b[11]  = mask[6];
      b[12]  = mask[9];
      b[14]  = mask[7];
      b[15]  = mask[4];
      b[16]  = mask[5];
      return b;
   endfunction

   // Button number reported with each axis result, in emission order
   function automatic logic [4:0] axis_key(input logic [3:0] idx);
      logic [4:0] k;
      case (idx)
         4'd0:    k = 5'(BTN_L2);
         4'd1:    k = 5'(BTN_R2);
         4'd2:    k = 5'(BTN_LS_UP);
         4'd3:    k = 5'(BTN_LS_DN);
         4'd4:    k = 5'(BTN_LS_RT);
         4'd5:    k = 5'(BTN_LS_LT);
         4'd6:    k = 5'(BTN_RS_UP);
         4'd7:    k = 5'(BTN_RS_DN);
         4'd8:    k = 5'(BTN_RS_LT);
         4'd9:    k = 5'(BTN_RS_RT);
         default: k = '0;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

>>> design/gamepad_button_auto_repeat.sv
// ----------------------------------------------------------------------------
// Gamepad button auto-repeat
// Turns one gamepad poll into ten axis results followed by press, release
// and repeat events for 25 buttons, with per-button repeat times in a RAM.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | req_tdata (poll fields)
//  rsp     | out | rsp_tvalid/rsp_tready | rsp_tdata, rsp_tuser, rsp_tlast
//  csr     | in  | csr_we                | csr_index, csr_wdata
//
// A poll runs through an accept step, 10 axis results, 25 button slots
// (one repeat-time RAM entry each) and a final step that releases the
// final result, which is held back to mark it with tlast.
// req_tready is high only between polls.
// Reset (synchronous) clears control state and loads register defaults;
// the repeat-time RAM is not cleared, since an entry is read only for a
// button held since a press that wrote it.
// The sequencer pauses while the output register is full and not taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gamepad_button_auto_repeat_defines.svh"

module gamepad_button_auto_repeat #(
   parameter int TIME_WIDTH = 32   // 16 .. 64
) (
   input  wire                              clock,
   input  wire                              reset,
   // button_mask, left_trigger, right_trigger, left_x, left_y, right_x,
   // right_y, now_tick
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire [gbar_pkg::REQ_DATA_W-1:0]   req_tdata,
   // key, event_res, axis_value, zero pad
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [gbar_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // kind, user
   output logic [gbar_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                             rsp_tlast,
   input  wire                              csr_we,
   input  wire [gbar_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire [gbar_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_AXIS  = 2'd1;
   localparam logic [1:0] ST_BTN   = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   localparam logic [4:0] LAST_AXIS = 5'(gbar_pkg::AXIS_COUNT - 1);
   localparam logic [4:0] LAST_BTN  = 5'(gbar_pkg::NUM_BUTTONS - 1);

   // Configuration registers
   logic [14:0] left_dz_ff;
   logic [14:0] right_dz_ff;
   logic [7:0]  left_thr_ff;
   logic [7:0]  right_thr_ff;
   logic [15:0] first_delay_ff;
   logic [15:0] period_ff;
   logic [1:0]  pad_id_ff;

   // Sequencer
   logic [1:0]  state_ff, state_in;
   logic [4:0]  idx_ff, idx_in;

   // Poll registers
   logic [TIME_WIDTH-1:0] now_ff;
   logic [gbar_pkg::NUM_BUTTONS-1:0] cur_ff, held_ff;
   logic signed [15:0] lt_av_ff, rt_av_ff, lx_av_ff, ly_av_ff, rx_av_ff, ry_av_ff;

   // Repeat-time RAM
   logic [TIME_WIDTH-1:0] due_mem [gbar_pkg::NUM_BUTTONS];
   logic [TIME_WIDTH-1:0] rd_data_ff;
   logic                  mem_we;
   logic [TIME_WIDTH-1:0] mem_wdata;

   // Held-back result and output register
   gbar_pkg::result_type hold_ff, rsp_res_ff, new_res;
   logic       hold_valid_ff;
   logic       rsp_tvalid_ff;
   logic       rsp_last_ff;
   logic [1:0] rsp_user_ff;
   logic       new_valid;
   logic       flush;
   logic       out_ok;

   // Unpacked request fields
   logic [15:0]        req_mask;
   logic [7:0]         req_lt, req_rt;
   logic signed [15:0] req_lx, req_ly, req_rx, req_ry;
   logic [gbar_pkg::TICK_EXT_W-1:0] req_now_ext;
   logic [gbar_pkg::NUM_BUTTONS-1:0] req_buttons;
   logic signed [15:0] left_pos, left_neg, right_pos, right_neg;
   logic ly_up, ly_dn, lx_lt, lx_rt, ry_up, ry_dn, rx_lt, rx_rt, lt_on, rt_on;

   // Button slot terms
   logic                  was, is_on;
   logic [TIME_WIDTH-1:0] due_diff;

   // Unpack the poll
   assign req_mask    = req_tdata[15:0];
   assign req_lt      = req_tdata[23:16];
   assign req_rt      = req_tdata[31:24];
   assign req_lx      = $signed(req_tdata[47:32]);
   assign req_ly      = $signed(req_tdata[63:48]);
   assign req_rx      = $signed(req_tdata[79:64]);
   assign req_ry      = $signed(req_tdata[95:80]);
   assign req_now_ext = {32'd0, req_tdata[127:96]};

   // Zone edges and the analog button decisions
   assign left_pos  = $signed({1'b0, left_dz_ff});
   assign left_neg  = -left_pos;
   assign right_pos = $signed({1'b0, right_dz_ff});
   assign right_neg = -right_pos;
   assign lt_on = req_lt > left_thr_ff;
   assign rt_on = req_rt > right_thr_ff;
   assign ly_up = req_ly > left_pos;
   assign ly_dn = req_ly < left_neg;
   assign lx_rt = req_lx > left_pos;
   assign lx_lt = req_lx < left_neg;
   assign ry_up = req_ry > right_pos;
   assign ry_dn = req_ry < right_neg;
   assign rx_rt = req_rx > right_pos;
   assign rx_lt = req_rx < right_neg;

   always_comb begin
      req_buttons = {8'd0, gbar_pkg::mask_to_buttons(req_mask)};
      req_buttons[gbar_pkg::BTN_L2]    = lt_on;
      req_buttons[gbar_pkg::BTN_R2]    = rt_on;
      req_buttons[gbar_pkg::BTN_LS_UP] = ly_up;
      req_buttons[gbar_pkg::BTN_LS_DN] = ly_dn;
      req_buttons[gbar_pkg::BTN_LS_LT] = lx_lt;
      req_buttons[gbar_pkg::BTN_LS_RT] = lx_rt;
      req_buttons[gbar_pkg::BTN_RS_UP] = ry_up;
      req_buttons[gbar_pkg::BTN_RS_DN] = ry_dn;
      req_buttons[gbar_pkg::BTN_RS_LT] = rx_lt;
      req_buttons[gbar_pkg::BTN_RS_RT] = rx_rt;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign out_ok     = !rsp_tvalid_ff || rsp_tready;

   // Current button slot
   assign was      = held_ff[idx_ff];
   assign is_on    = cur_ff[idx_ff];
   assign due_diff = now_ff - rd_data_ff;

   // Sequence one step per cycle while the output side has room
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      new_valid = 1'b0;
      new_res   = '0;
      mem_we    = 1'b0;
      mem_wdata = now_ff + TIME_WIDTH'(period_ff);
      flush     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_AXIS;
               idx_in   = '0;
            end
         end
         ST_AXIS: begin
            if (out_ok) begin
               new_valid      = 1'b1;
               new_res.kind   = gbar_pkg::KIND_AXIS;
               new_res.key    = gbar_pkg::axis_key(idx_ff[3:0]);
               case (idx_ff[3:0])
                  4'd0:       new_res.axis_value = lt_av_ff;
                  4'd1:       new_res.axis_value = rt_av_ff;
                  4'd2, 4'd3: new_res.axis_value = ly_av_ff;
                  4'd4, 4'd5: new_res.axis_value = lx_av_ff;
                  4'd6, 4'd7: new_res.axis_value = ry_av_ff;
                  default:    new_res.axis_value = rx_av_ff;
               endcase
               if (idx_ff == LAST_AXIS) begin
                  state_in = ST_BTN;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
         end
         ST_BTN: begin
            if (out_ok) begin
               new_res.kind = gbar_pkg::KIND_BUTTON;
               new_res.key  = idx_ff;
               if (was && is_on) begin
                  // Repeat when the due time is not in the future
                  if (!due_diff[TIME_WIDTH-1]) begin
                     new_valid         = 1'b1;
                     new_res.event_res = gbar_pkg::EV_REPEAT;
                     mem_we            = 1'b1;
                  end
               end else if (was) begin
                  new_valid         = 1'b1;
                  new_res.event_res = gbar_pkg::EV_RELEASE;
               end else if (is_on) begin
                  new_valid         = 1'b1;
                  new_res.event_res = gbar_pkg::EV_PRESS;
                  mem_we            = 1'b1;
                  mem_wdata         = now_ff + TIME_WIDTH'(first_delay_ff);
               end
               if (idx_ff == LAST_BTN) begin
                  state_in = ST_FLUSH;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
         end
         ST_FLUSH: begin
            if (out_ok) begin
               flush    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         left_dz_ff     <= 15'd7849;
         right_dz_ff    <= 15'd8689;
         left_thr_ff    <= 8'd30;
         right_thr_ff   <= 8'd30;
         first_delay_ff <= 16'd150;
         period_ff      <= 16'd300;
         pad_id_ff      <= 2'd0;
      end else if (csr_we) begin
         case (csr_index)
            gbar_pkg::REG_LEFT_DZ:     left_dz_ff     <= csr_wdata[14:0];
            gbar_pkg::REG_RIGHT_DZ:    right_dz_ff    <= csr_wdata[14:0];
            gbar_pkg::REG_LEFT_THR:    left_thr_ff    <= csr_wdata[7:0];
            gbar_pkg::REG_RIGHT_THR:   right_thr_ff   <= csr_wdata[7:0];
            gbar_pkg::REG_FIRST_DELAY: first_delay_ff <= csr_wdata;
            gbar_pkg::REG_PERIOD:      period_ff      <= csr_wdata;
            gbar_pkg::REG_PAD_ID:      pad_id_ff      <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Sequencer and button history
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         held_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (flush) begin
            held_ff <= cur_ff;
         end
      end
   end

   // Capture the poll on transfer; zero analog values inside their zone
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         now_ff   <= req_now_ext[TIME_WIDTH-1:0];
         cur_ff   <= req_buttons;
         lt_av_ff <= lt_on ? $signed({8'd0, req_lt}) : 16'sd0;
         rt_av_ff <= rt_on ? $signed({8'd0, req_rt}) : 16'sd0;
         ly_av_ff <= (ly_up || ly_dn) ? req_ly : 16'sd0;
         lx_av_ff <= (lx_rt || lx_lt) ? req_lx : 16'sd0;
         ry_av_ff <= (ry_up || ry_dn) ? req_ry : 16'sd0;
         rx_av_ff <= (rx_rt || rx_lt) ? req_rx : 16'sd0;
      end
   end

   // Repeat-time RAM: read the next slot's entry, write back the current one.
   // The read address is the next index, so a write never meets a read of
   // the same entry in the same cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         due_mem[idx_ff] <= mem_wdata;
      end
      rd_data_ff <= due_mem[idx_in];
   end

   // Hold back the newest result; push the previous one out
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (new_valid) begin
            hold_valid_ff <= 1'b1;
         end else if (flush) begin
            hold_valid_ff <= 1'b0;
         end
         if ((new_valid && hold_valid_ff) || flush) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (new_valid) begin
         hold_ff <= new_res;
      end
      if ((new_valid && hold_valid_ff) || flush) begin
         rsp_res_ff  <= hold_ff;
         rsp_user_ff <= pad_id_ff;
         rsp_last_ff <= flush;
      end
   end

   // Drive the result channel
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, rsp_res_ff.axis_value, rsp_res_ff.event_res, rsp_res_ff.key};
   assign rsp_tuser  = {rsp_user_ff, rsp_res_ff.kind};
   assign rsp_tlast  = rsp_last_ff;

   // Checks
   `GBAR_ASSERT_SAME(a_btn_index_range, state_ff == ST_BTN, idx_ff <= LAST_BTN, "button index out of range")
   `GBAR_ASSERT_SAME(a_hold_filled, (state_ff == ST_BTN) || (state_ff == ST_FLUSH), hold_valid_ff, "no held-back result after axis phase")
   `GBAR_ASSERT_NEXT(a_history_update, flush, held_ff == $past(cur_ff) && rsp_tlast && rsp_tvalid, "poll end did not update history or mark tlast")
   `GBAR_ASSERT_SAME(a_ram_write_in_scan, mem_we, (state_ff == ST_BTN) && out_ok, "repeat-time write outside button scan")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Gamepad auto-repeat testbench
// Drives polls into the auto-repeat block and checks every axis result and
// button event against a scoreboard that tracks held buttons and per-button
// repeat times. A short directed pass at reset defaults runs first, then
// random sessions under several register settings, including the extremes.
// Both stream sides idle in random bursts, except in the final phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   localparam int          CYCLE_LIMIT = 1000000;
   localparam logic [2:0]  REG_UNUSED  = 3'd7;

   // One poll, packed the way req_tdata carries it (last field lowest)
   typedef struct packed {
      logic [31:0]        tick;
      logic signed [15:0] ry;
      logic signed [15:0] rx;
      logic signed [15:0] ly;
      logic signed [15:0] lx;
      logic [7:0]         rt;
      logic [7:0]         lt;
      logic [15:0]        mask;
   } poll_type;

   typedef struct {
      logic        kind;
      logic [4:0]  key;
      logic [1:0]  ev;
      logic [15:0] value;
      logic [1:0]  user;
      logic        last;
   } owed_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [gbar_pkg::REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [gbar_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic [gbar_pkg::RSP_USER_W-1:0]  rsp_tuser;
   logic                             rsp_tlast;
   logic                             csr_we     = 1'b0;
   logic [gbar_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [gbar_pkg::CSR_DATA_W-1:0]  csr_wdata  = '0;

   // Register copies
   logic [14:0] cfg_left_dz   = 15'd7849;
   logic [14:0] cfg_right_dz  = 15'd8689;
   logic [7:0]  cfg_left_thr  = 8'd30;
   logic [7:0]  cfg_right_thr = 8'd30;
   logic [15:0] cfg_delay     = 16'd150;
   logic [15:0] cfg_period    = 16'd300;
   logic [1:0]  cfg_pad       = 2'd0;

   // Button state copies
   logic [24:0] held_now = '0;
   logic [31:0] repeat_at [25];

   poll_type polls_to_send [$];
   owed_type owed_results [$];
   poll_type live_poll   = '0;
   bit       poll_live   = 1'b0;
   bit       poll_taken  = 1'b0;
   bit       idle_on     = 1'b1;
   int       req_gap     = 0;
   int       rsp_hold    = 0;
   int       mismatches  = 0;
   int       cycles      = 0;
   int       tick_step   = 400;

   gamepad_button_auto_repeat DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      // button_mask, left_trigger, right_trigger, left_x, left_y, right_x,
      // right_y, now_tick
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // key, event_res, axis_value, zero pad
      .rsp_tdata  (rsp_tdata),
      // kind, user
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Mask bit behind each digital button, -1 where none drives it
   function automatic int mask_bit_of(int btn);
      case (btn)
         0:       return 14;
         1:       return 12;
         2:       return 13;
         3:       return 15;
         4:       return 0;
         5:       return 1;
         6:       return 2;
         7:       return 3;
         9:       return 8;
         11:      return 6;
         12:      return 9;
         14:      return 7;
         15:      return 4;
         16:      return 5;
         default: return -1;
      endcase
   endfunction

   function automatic void queue_result(logic kind, int key, logic [1:0] ev,
                                        logic [15:0] value, bit last);
      owed_type r;
      r.kind  = kind;
      r.key   = 5'(key);
      r.ev    = ev;
      r.value = value;
      r.user  = cfg_pad;
      r.last  = last;
      owed_results.push_back(r);
   endfunction

   // Work out the axis results and button events of one poll
   function automatic void scan_poll(poll_type p);
      int          lx, ly, rx, ry, ldz, rdz, mb, nev, k;
      logic [24:0] down;
      logic [31:0] elapsed;
      bit          fires [25];
      logic [1:0]  code [25];
      logic [15:0] trig_l, trig_r, lyv, lxv, ryv, rxv;
      lx   = $signed(p.lx);
      ly   = $signed(p.ly);
      rx   = $signed(p.rx);
      ry   = $signed(p.ry);
      ldz  = cfg_left_dz;
      rdz  = cfg_right_dz;
      down = '0;
      for (int b = 0; b < 17; b++) begin
         mb = mask_bit_of(b);
         if (mb >= 0 && p.mask[mb]) down[b] = 1'b1;
      end
      down[gbar_pkg::BTN_L2]    = p.lt > cfg_left_thr;
      down[gbar_pkg::BTN_R2]    = p.rt > cfg_right_thr;
      down[gbar_pkg::BTN_LS_UP] = ly > ldz;
      down[gbar_pkg::BTN_LS_DN] = ly < -ldz;
      down[gbar_pkg::BTN_LS_LT] = lx < -ldz;
      down[gbar_pkg::BTN_LS_RT] = lx > ldz;
      down[gbar_pkg::BTN_RS_UP] = ry > rdz;
      down[gbar_pkg::BTN_RS_DN] = ry < -rdz;
      down[gbar_pkg::BTN_RS_LT] = rx < -rdz;
      down[gbar_pkg::BTN_RS_RT] = rx > rdz;

      // Compare with the held set; a held button repeats once its time is due
      nev = 0;
      for (int b = 0; b < 25; b++) begin
         fires[b] = 1'b0;
         code[b]  = gbar_pkg::EV_PRESS;
         if (held_now[b] && down[b]) begin
            elapsed = p.tick - repeat_at[b];
            if (!elapsed[31]) begin
               fires[b]     = 1'b1;
               code[b]      = gbar_pkg::EV_REPEAT;
               repeat_at[b] = p.tick + 32'(cfg_period);
            end
         end else if (held_now[b]) begin
            fires[b] = 1'b1;
            code[b]  = gbar_pkg::EV_RELEASE;
         end else if (down[b]) begin
            fires[b]     = 1'b1;
            code[b]      = gbar_pkg::EV_PRESS;
            repeat_at[b] = p.tick + 32'(cfg_delay);
         end
         if (fires[b]) nev++;
      end
      held_now = down;

      trig_l = down[gbar_pkg::BTN_L2] ? {8'd0, p.lt} : 16'd0;
      trig_r = down[gbar_pkg::BTN_R2] ? {8'd0, p.rt} : 16'd0;
      lyv    = (down[gbar_pkg::BTN_LS_UP] || down[gbar_pkg::BTN_LS_DN]) ? p.ly : 16'd0;
      lxv    = (down[gbar_pkg::BTN_LS_LT] || down[gbar_pkg::BTN_LS_RT]) ? p.lx : 16'd0;
      ryv    = (down[gbar_pkg::BTN_RS_UP] || down[gbar_pkg::BTN_RS_DN]) ? p.ry : 16'd0;
      rxv    = (down[gbar_pkg::BTN_RS_LT] || down[gbar_pkg::BTN_RS_RT]) ? p.rx : 16'd0;
      queue_result(gbar_pkg::KIND_AXIS, gbar_pkg::BTN_L2, gbar_pkg::EV_PRESS, trig_l, 1'b0);
      queue_result(gbar_pkg::KIND_AXIS, gbar_pkg::BTN_R2, gbar_pkg::EV_PRESS, trig_r, 1'b0);
      queue_result(gbar_pkg::KIND_AXIS, gbar_pkg::BTN_LS_UP, gbar_pkg::EV_PRESS, lyv, 1'b0);
      queue_result(gbar_pkg::KIND_AXIS, gbar_pkg::BTN_LS_DN, gbar_pkg::EV_PRESS, lyv, 1'b0);
      queue_result(gbar_pkg::KIND_AXIS, gbar_pkg::BTN_LS_RT, gbar_pkg::EV_PRESS, lxv, 1'b0);
      queue_result(gbar_pkg::KIND_AXIS, gbar_pkg::BTN_LS_LT, gbar_pkg::EV_PRESS, lxv, 1'b0);
      queue_result(gbar_pkg::KIND_AXIS, gbar_pkg::BTN_RS_UP, gbar_pkg::EV_PRESS, ryv, 1'b0);
      queue_result(gbar_pkg::KIND_AXIS, gbar_pkg::BTN_RS_DN, gbar_pkg::EV_PRESS, ryv, 1'b0);
      queue_result(gbar_pkg::KIND_AXIS, gbar_pkg::BTN_RS_LT, gbar_pkg::EV_PRESS, rxv, 1'b0);
      queue_result(gbar_pkg::KIND_AXIS, gbar_pkg::BTN_RS_RT, gbar_pkg::EV_PRESS, rxv,
                   nev == 0);
      k = 0;
      for (int b = 0; b < 25; b++) begin
         if (fires[b]) begin
            k++;
            queue_result(gbar_pkg::KIND_BUTTON, b, code[b], 16'd0, k == nev);
         end
      end
   endfunction

   function automatic poll_type make_poll(logic [15:0] mask, int lt, int rt, int lx,
                                          int ly, int rx, int ry, logic [31:0] tick);
      poll_type p;
      p.mask = mask;
      p.lt   = 8'(lt);
      p.rt   = 8'(rt);
      p.lx   = 16'(lx);
      p.ly   = 16'(ly);
      p.rx   = 16'(rx);
      p.ry   = 16'(ry);
      p.tick = tick;
      return p;
   endfunction

   // Trigger value near the threshold edge, at the extremes or anywhere
   function automatic logic [7:0] pick_trigger(logic [7:0] thr);
      case ($urandom_range(0, 4))
         0:       return 8'd0;
         1:       return thr;
         2:       return (thr == 8'd255) ? thr : thr + 8'd1;
         3:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Stick value on or just past the zone edge, at the extremes or anywhere
   function automatic logic [15:0] pick_axis(logic [14:0] zone);
      int z, v;
      z = zone;
      case ($urandom_range(0, 6))
         0:       v = 0;
         1:       v = z;
         2:       v = -z;
         3:       v = z + 1;
         4:       v = -z - 1;
         5:       v = $urandom_range(0, 1) ? 32767 : -32768;
         default: v = int'($urandom_range(0, 65535)) - 32768;
      endcase
      if (v > 32767) v = 32767;
      return 16'(v);
   endfunction

   // Mostly small changes to a held pad state, some noise, some bulk changes
   function automatic poll_type next_poll(poll_type p);
      poll_type q;
      int       pick;
      q    = p;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         if ($urandom_range(0, 2) == 0) q.mask = q.mask ^ (16'd1 << $urandom_range(0, 15));
         if ($urandom_range(0, 5) == 0) q.lt = pick_trigger(cfg_left_thr);
         if ($urandom_range(0, 5) == 0) q.rt = pick_trigger(cfg_right_thr);
         if ($urandom_range(0, 4) == 0) q.lx = pick_axis(cfg_left_dz);
         if ($urandom_range(0, 4) == 0) q.ly = pick_axis(cfg_left_dz);
         if ($urandom_range(0, 4) == 0) q.rx = pick_axis(cfg_right_dz);
         if ($urandom_range(0, 4) == 0) q.ry = pick_axis(cfg_right_dz);
         q.tick = p.tick + $urandom_range(0, tick_step);
      end else if (pick < 90) begin
         q = {$urandom, $urandom, $urandom, $urandom};
      end else if (pick < 95) begin
         q      = make_poll(16'h0000, 0, 0, 0, 0, 0, 0, p.tick);
         q.tick = p.tick + $urandom_range(0, tick_step);
      end else begin
         q.mask = 16'hFFFF;
         q.tick = p.tick + $urandom_range(0, tick_step);
      end
      return q;
   endfunction

   task automatic flag_mismatch(string msg);
      mismatches++;
      $display("MISMATCH at cycle %0d: %s", cycles, msg);
   endtask

   // Write one register and update the local copy
   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         gbar_pkg::REG_LEFT_DZ:     cfg_left_dz   = val[14:0];
         gbar_pkg::REG_RIGHT_DZ:    cfg_right_dz  = val[14:0];
         gbar_pkg::REG_LEFT_THR:    cfg_left_thr  = val[7:0];
         gbar_pkg::REG_RIGHT_THR:   cfg_right_thr = val[7:0];
         gbar_pkg::REG_FIRST_DELAY: cfg_delay     = val;
         gbar_pkg::REG_PERIOD:      cfg_period    = val;
         gbar_pkg::REG_PAD_ID:      cfg_pad       = val[1:0];
         default:                   ;
      endcase
   endtask

   task automatic close_writes();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Hold until every poll went out and every owed result came back
   task automatic drain();
      while (polls_to_send.size() != 0 || poll_live || owed_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic queue_random(int count);
      poll_type p;
      p = polls_to_send.size() != 0 ? polls_to_send[polls_to_send.size() - 1] : live_poll;
      repeat (count) begin
         p = next_poll(p);
         polls_to_send.push_back(p);
      end
   endtask

   // Poll driver: present the next poll, with random gaps between polls
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (poll_taken) begin
            poll_taken = 1'b0;
            poll_live  = 1'b0;
            if (idle_on && $urandom_range(0, 3) == 0) req_gap = $urandom_range(1, 19);
         end
         if (!poll_live) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (polls_to_send.size() != 0) begin
               live_poll = polls_to_send.pop_front();
               poll_live = 1'b1;
            end
         end
         req_tvalid <= poll_live;
         req_tdata  <= live_poll;
      end
   end

   // Result sink: stall in random bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_hold > 0) rsp_hold--;
         else if (idle_on && $urandom_range(0, 15) == 0) rsp_hold = $urandom_range(1, 19);
         rsp_tready <= (rsp_hold == 0);
      end
   end

   // Monitor: predict on each poll transfer, check each result transfer
   always @(posedge clock) begin
      owed_type want;
      cycles++;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            scan_poll(live_poll);
            poll_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (owed_results.size() == 0) begin
               flag_mismatch("result transfer with nothing owed");
            end else begin
               want = owed_results.pop_front();
               if (rsp_tuser[0] !== want.kind)
                  flag_mismatch($sformatf("kind %0b, want %0b", rsp_tuser[0], want.kind));
               if (rsp_tdata[4:0] !== want.key)
                  flag_mismatch($sformatf("key %0d, want %0d", rsp_tdata[4:0], want.key));
               if (rsp_tdata[6:5] !== want.ev)
                  flag_mismatch($sformatf("event %0d, want %0d (key %0d)",
                                          rsp_tdata[6:5], want.ev, want.key));
               if (rsp_tdata[22:7] !== want.value)
                  flag_mismatch($sformatf("value %h, want %h (key %0d)",
                                          rsp_tdata[22:7], want.value, want.key));
               if (rsp_tdata[23] !== 1'b0)
                  flag_mismatch("pad bit of tdata set");
               if (rsp_tuser[2:1] !== want.user)
                  flag_mismatch($sformatf("user %0d, want %0d", rsp_tuser[2:1], want.user));
               if (rsp_tlast !== want.last)
                  flag_mismatch($sformatf("last %0b, want %0b (key %0d)",
                                          rsp_tlast, want.last, want.key));
            end
         end
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed polls at reset defaults: extremes, zone edges, repeat timing
      polls_to_send.push_back(make_poll(16'h0000, 0, 0, 0, 0, 0, 0, 32'd0));
      polls_to_send.push_back(make_poll(16'hFFFF, 255, 255, 32767, -32768, -32768, 32767,
                                        32'd10));
      polls_to_send.push_back(make_poll(16'hFFFF, 255, 255, 32767, -32768, -32768, 32767,
                                        32'd159));
      polls_to_send.push_back(make_poll(16'hFFFF, 255, 255, 32767, -32768, -32768, 32767,
                                        32'd160));
      polls_to_send.push_back(make_poll(16'h0C00, 30, 30, 7849, -7849, 8689, -8689, 32'd170));
      polls_to_send.push_back(make_poll(16'h0000, 31, 31, -7850, 7850, 8690, -8690,
                                        32'hFFFFFF00));
      polls_to_send.push_back(make_poll(16'h0000, 31, 31, -7850, 7850, 8690, -8690,
                                        32'h00000100));
      polls_to_send.push_back(make_poll(16'h5555, 0, 255, -32768, 32767, 0, 0, 32'h80000000));
      polls_to_send.push_back(make_poll(16'hAAAA, 0, 255, -32768, 32767, 0, 0, 32'h80000000));
      polls_to_send.push_back(make_poll(16'hAAAA, 0, 255, -32768, 32767, 0, 0, 32'h80000096));
      polls_to_send.push_back(make_poll(16'hAAAA, 0, 255, -32768, 32767, 0, 0, 32'h800001C1));
      polls_to_send.push_back(make_poll(16'hAAAA, 0, 255, -32768, 32767, 0, 0, 32'h800001C2));
      polls_to_send.push_back(make_poll(16'h0000, 0, 0, 0, 0, 0, 0, 32'h00000001));
      polls_to_send.push_back(make_poll(16'h1234, 200, 5, -1, 1, -32767, 32766, 32'hFFFFFFFF));
      polls_to_send.push_back(make_poll(16'hEDCB, 5, 200, 1, -1, 32766, -32767, 32'h0));
      drain();

      // Zero zones and thresholds, repeats due at every poll
      write_reg(gbar_pkg::REG_LEFT_DZ, 16'd0);
      write_reg(gbar_pkg::REG_RIGHT_DZ, 16'd0);
      write_reg(gbar_pkg::REG_LEFT_THR, 16'd0);
      write_reg(gbar_pkg::REG_RIGHT_THR, 16'd0);
      write_reg(gbar_pkg::REG_FIRST_DELAY, 16'd0);
      write_reg(gbar_pkg::REG_PERIOD, 16'd0);
      write_reg(gbar_pkg::REG_PAD_ID, 16'd1);
      write_reg(REG_UNUSED, 16'hFFFF);
      close_writes();
      tick_step = 3;
      queue_random(60);
      drain();

      // Typical settings
      write_reg(gbar_pkg::REG_LEFT_DZ, 16'd7849);
      write_reg(gbar_pkg::REG_RIGHT_DZ, 16'd8689);
      write_reg(gbar_pkg::REG_LEFT_THR, 16'd30);
      write_reg(gbar_pkg::REG_RIGHT_THR, 16'd30);
      write_reg(gbar_pkg::REG_FIRST_DELAY, 16'd150);
      write_reg(gbar_pkg::REG_PERIOD, 16'd300);
      write_reg(gbar_pkg::REG_PAD_ID, 16'd2);
      close_writes();
      tick_step = 500;
      queue_random(120);
      drain();

      // All-ones settings: widest zones, highest thresholds, longest delays
      write_reg(gbar_pkg::REG_LEFT_DZ, 16'hFFFF);
      write_reg(gbar_pkg::REG_RIGHT_DZ, 16'h7FFF);
      write_reg(gbar_pkg::REG_LEFT_THR, 16'hFFFF);
      write_reg(gbar_pkg::REG_RIGHT_THR, 16'h00FF);
      write_reg(gbar_pkg::REG_FIRST_DELAY, 16'hFFFF);
      write_reg(gbar_pkg::REG_PERIOD, 16'hFFFF);
      write_reg(gbar_pkg::REG_PAD_ID, 16'hFFFF);
      close_writes();
      tick_step = 40000;
      queue_random(60);
      drain();

      // Random zones, fast repeats, no idling on either side
      write_reg(gbar_pkg::REG_LEFT_DZ, 16'($urandom_range(0, 32767)));
      write_reg(gbar_pkg::REG_RIGHT_DZ, 16'($urandom_range(0, 32767)));
      write_reg(gbar_pkg::REG_LEFT_THR, 16'($urandom_range(0, 255)));
      write_reg(gbar_pkg::REG_RIGHT_THR, 16'($urandom_range(0, 255)));
      write_reg(gbar_pkg::REG_FIRST_DELAY, 16'd5);
      write_reg(gbar_pkg::REG_PERIOD, 16'd3);
      write_reg(gbar_pkg::REG_PAD_ID, 16'd0);
      close_writes();
      idle_on   = 1'b0;
      tick_step = 12;
      queue_random(130);
      drain();

      repeat (40) @(posedge clock);
      if (mismatches == 0 && owed_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
+incdir+design
design/gbar_pkg.sv
design/gamepad_button_auto_repeat.sv
tb/tb_top.sv
